// ===== rtl/cltb_pkg.sv =====
// Package for the cartridge logic register with tape bit.
// Holds the action codes, window and threshold constants and the register update
// function. Has no dependencies.
package cltb_pkg;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_PUSH  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  // Configuration register indexes
  localparam logic CFG_CYCLE_SCALE   = 1'b0;
  localparam logic CFG_SAMPLE_PERIOD = 1'b1;

  localparam int unsigned QueueDepthDefault = 4096;

  localparam int unsigned ScaleW  = 24;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned CyclesW = 10;
  localparam int unsigned ProdW   = ScaleW + CyclesW;
  localparam int unsigned AccW    = 33;

  localparam logic [ScaleW-1:0]  CycleScaleReset   = 24'd65536;
  localparam logic [PeriodW-1:0] SamplePeriodReset = 32'd2659635;
  localparam logic [AccW-1:0]    AccMax            = {AccW{1'b1}};
  localparam logic [7:0]         LogicRegReset     = 8'hFF;

  // 0x8000-0x9FFF window: top three address bits are 100
  localparam logic [2:0]         WinTopBits        = 3'b100;
  localparam logic signed [15:0] TapeThreshold     = -16'sd1000;

  // Next logic register value on a write inside the window
  function automatic logic [7:0] next_logic(input logic [3:0] d, input logic a,
                                            input logic b, input logic [7:0] r,
                                            input logic t);
    logic na, nb, nd0;
    logic [3:0] x;
    logic [7:0] o;
    na  = ~a;
    nb  = ~b;
    nd0 = ~d[0];
    x   = d ^ r[3:0];
    o[0] = (d[0] & na & nb) | (x[0] & na & b) | (d[0] & a & nb) | (r[0] & a & nb)
         | (d[0] & r[0] & a & b);
    o[1] = (d[1] & na & nb) | (x[1] & na & b) | (d[1] & a & nb) | (r[1] & a & nb)
         | (nd0 & d[1] & r[1] & a & b) | (d[0] & r[1] & a & b);
    o[2] = (d[2] & na & nb) | (x[2] & na & b) | (d[2] & a & nb) | (r[2] & a & nb)
         | (nd0 & d[2] & r[2] & a & b) | (d[0] & r[2] & a & b);
    o[3] = (d[3] & na & nb) | (x[3] & na & b) | (d[3] & a & nb) | (r[3] & a & nb)
         | (nd0 & d[3] & r[3] & a & b) | (d[0] & r[3] & a & b);
    o[4] = (na & r[4] & nb) | (x[3] & na & b) | (a & r[4] & nb) | (d[3] & a & nb)
         | (d[0] & (r[3] ^ r[4]) & a & b) | (nd0 & a & b & t);
    o[5] = (na & nb & r[5]) | (x[2] & na & b) | (a & nb & r[5]) | (d[2] & a & nb)
         | (d[0] & (r[2] ^ r[5]) & a & b);
    o[6] = (na & nb & r[6]) | (x[1] & na & b) | (a & nb & r[6]) | (d[1] & a & nb)
         | (d[0] & (r[1] ^ r[6]) & a & b);
    o[7] = (na & nb & r[7]) | (x[0] & na & b) | (a & nb & r[7]) | (d[1] & a & nb)
         | (d[0] & (r[0] ^ r[7]) & a & b);
    // outputs 4..7 land reversed in bits 7..4
    return {o[4], o[5], o[6], o[7], o[3:0]};
  endfunction

endpackage

// ===== rtl/cart_logic_register_with_tape_bit_top.sv =====
// Top level of the cartridge logic register with tape bit.
// Three-stage pipeline around a sample FIFO memory; uses cltb_pkg.
//
// Cartridge logic register with cassette tape bit. Every transaction on the slave
// stream (tuser = action: tick, bus write, push sample, clear queue) yields exactly one
// result on the master stream in order, out of the stage 3 output register. One transaction is taken
// every cycle; both sides stall together when the output register holds an untaken
// result. Stage 1 registers the cycles-times-scale product, stage 2 updates the
// accumulator and FIFO pointers and does the single FIFO memory access (push write or
// pop read), stage 3 applies the popped sample to the tape bit and the write to the
// logic register. The FIFO holds QUEUE_DEPTH samples in one synchronous memory and needs
// no clearing after reset. Configuration writes are taken at any cycle but must only be
// issued while the pipeline is empty.
module cart_logic_register_with_tape_bit_top
  import cltb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // cycles[9:0], addr[25:10], wdata[33:26],
                                      // sample[49:34], zero pad[55:50]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // reg_value[7:0], tape_bit[8], write_taken[9],
                                      // sample_dropped[10], zero pad[15:11]
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // input fields
  logic [CyclesW-1:0] in_cycles;
  logic [15:0]        in_addr;
  logic [7:0]         in_wdata;
  logic [15:0]        in_sample;
  assign in_cycles = s_axis_tdata[9:0];
  assign in_addr   = s_axis_tdata[25:10];
  assign in_wdata  = s_axis_tdata[33:26];
  assign in_sample = s_axis_tdata[49:34];

  // configuration registers
  logic [ScaleW-1:0]  cycle_scale_q;
  logic [PeriodW-1:0] sample_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_scale_q   <= CycleScaleReset;
      sample_period_q <= SamplePeriodReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_CYCLE_SCALE:   cycle_scale_q   <= cfg_wdata_i[ScaleW-1:0];
        CFG_SAMPLE_PERIOD: sample_period_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // global advance: whole pipeline moves when the output register can take a result
  logic advance;
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // ---------------- stage 1: product and field capture ----------------
  logic               s1_valid_q;
  action_e            s1_action_q;
  logic [ProdW-1:0]   s1_prod_q;
  logic               s1_hit_q;
  logic [1:0]         s1_ab_q;
  logic [3:0]         s1_wdata_q;
  logic [15:0]        s1_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_action_q <= action_e'(s_axis_tuser);
      s1_prod_q   <= ProdW'(in_cycles) * ProdW'(cycle_scale_q);
      s1_hit_q    <= (in_addr[15:13] == WinTopBits);
      s1_ab_q     <= in_addr[2:1];
      s1_wdata_q  <= in_wdata[3:0];
      s1_sample_q <= in_sample;
    end
  end

  // ---------------- stage 2: accumulator, queue pointers, memory access ----------------
  logic [AccW-1:0] accum_q, accum_d;
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;

  logic [AccW+1:0] sum_wide;
  logic [AccW-1:0] sum_sat;
  logic            reach;
  logic [CntW:0]   tail_wide;
  logic [PtrW-1:0] tail;
  logic            push_ok, pop_go, pop_has, dropped;

  assign sum_wide = (AccW+2)'(accum_q) + (AccW+2)'(s1_prod_q);
  assign sum_sat  = (sum_wide > (AccW+2)'(AccMax)) ? AccMax : sum_wide[AccW-1:0];
  assign reach    = sum_sat >= AccW'(sample_period_q);

  always_comb begin
    tail_wide = (CntW+1)'(head_q) + (CntW+1)'(count_q);
    if (tail_wide >= (CntW+1)'(QUEUE_DEPTH)) begin
      tail_wide = tail_wide - (CntW+1)'(QUEUE_DEPTH);
    end
  end
  assign tail = tail_wide[PtrW-1:0];

  always_comb begin
    accum_d = accum_q;
    head_d  = head_q;
    count_d = count_q;
    push_ok = 1'b0;
    pop_go  = 1'b0;
    pop_has = 1'b0;
    dropped = 1'b0;
    unique case (s1_action_q)
      ACT_TICK: begin
        accum_d = reach ? (sum_sat - AccW'(sample_period_q)) : sum_sat;
        pop_go  = reach;
        pop_has = reach && (count_q != '0);
        if (pop_has) begin
          head_d  = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      ACT_WRITE: ;
      ACT_PUSH: begin
        if (count_q == CntW'(QUEUE_DEPTH)) begin
          dropped = 1'b1;
        end else begin
          push_ok = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      ACT_CLEAR: begin
        head_d  = '0;
        count_d = '0;
      end
      default: ;
    endcase
  end

  logic s2_step;
  assign s2_step = advance && s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      head_q  <= '0;
      count_q <= '0;
    end else if (s2_step) begin
      accum_q <= accum_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // sample FIFO memory: at most one write or one read per transaction
  logic [15:0] queue_mem [QUEUE_DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (s2_step && push_ok) begin
      queue_mem[tail] <= s1_sample_q;
    end
    if (s2_step && pop_has) begin
      rdata_q <= queue_mem[head_q];
    end
  end

  // stage 2 -> 3 pipeline register
  logic       s2_valid_q;
  logic       s2_write_q;
  logic [1:0] s2_ab_q;
  logic [3:0] s2_wdata_q;
  logic       s2_pop_q, s2_has_q, s2_dropped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_step) begin
      s2_write_q   <= (s1_action_q == ACT_WRITE) && s1_hit_q;
      s2_ab_q      <= s1_ab_q;
      s2_wdata_q   <= s1_wdata_q;
      s2_pop_q     <= pop_go;
      s2_has_q     <= pop_has;
      s2_dropped_q <= dropped;
    end
  end

  // ---------------- stage 3: tape bit, logic register, result ----------------
  logic [7:0] logic_reg_q, logic_reg_d;
  logic       tape_q, tape_d;

  always_comb begin
    tape_d      = tape_q;
    logic_reg_d = logic_reg_q;
    if (s2_pop_q) begin
      tape_d = s2_has_q && ($signed(rdata_q) <= TapeThreshold);
    end
    if (s2_write_q) begin
      logic_reg_d = next_logic(s2_wdata_q, s2_ab_q[1], s2_ab_q[0], logic_reg_q, tape_q);
    end
  end

  logic s3_step;
  assign s3_step = advance && s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      logic_reg_q   <= LogicRegReset;
      tape_q        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        m_axis_tvalid <= s2_valid_q;
      end
      if (s3_step) begin
        logic_reg_q <= logic_reg_d;
        tape_q      <= tape_d;
      end
    end
  end

  // output register
  logic [15:0] out_data_q;
  always_ff @(posedge clk_i) begin
    if (s3_step) begin
      out_data_q <= {5'b0, s2_dropped_q, s2_write_q, tape_d, logic_reg_d};
    end
  end
  assign m_axis_tdata = out_data_q;

endmodule
